[rtl/tone_dial_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// Tone dial sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef TONE_DIAL_SEQUENCER_CORE_DEFINES_SVH
`define TONE_DIAL_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TDS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tds_pkg.sv]
// ----------------------------------------------------------------------------
// Tone dial sequencer package
// Field widths, opcodes, phase and status codes, controller command type.
// ----------------------------------------------------------------------------
package tds_pkg;

    // field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int TICK_W  = 16;
    localparam int STAT_W  = 2;
    localparam int PHASE_W = 2;
    localparam int CFG_A_W = 1;

    // input opcodes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SPACE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_MARK  = 2'd2;

    // result status
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BUSY = 2'd1;
    localparam logic [STAT_W-1:0] ST_LEN  = 2'd2;

    // register indexes
    localparam logic [CFG_A_W-1:0] CFG_SPACE = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_MARK  = 1'b1;

    // register reset values and the tick saturation value
    localparam logic [TICK_W-1:0] SPACE_RST = 16'd100;
    localparam logic [TICK_W-1:0] MARK_RST  = 16'd200;
    localparam logic [TICK_W-1:0] TICK_SAT  = 16'hFFFF;

    // controller to datapath commands
    typedef struct packed {
        logic step;   // apply the accepted word to the sequencer state
        logic latch;  // capture the result word
    } tds_cmd_t;

endpackage

[rtl/tone_dial_sequencer_core.sv]
// Tone dial sequencer core.
// Input words (s_ channel) carry an opcode in s_tuser: tick, append code or
// start dialing; s_tdata carries the code character for appends. Every
// accepted word yields exactly one result word on the m_ channel: whether
// the tone output changed, tone on/off, the code being played, idle flag
// and a status (accepted, busy, bad length).
// Timing: an accepted word steps the sequencer state and the registered
// code store read; the result is latched in S_READ and offered on m_tvalid
// in S_SEND. One word is handled at a time: s_tready stays low until the
// result is taken, and a stalled m_tready holds it. The config port (cfg_we,
// cfg_addr, cfg_wdata) writes space_ticks (index 0) and mark_ticks (index 1);
// the user must write them only while the block is idle; no check enforces it.
// Reset (aresetn low, synchronous) returns the sequencer to idle with no
// codes loaded, space_ticks to 100 and mark_ticks to 200; the code store
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Tone dial sequencer top level
// Joins the handshake controller and the sequencer datapath.
// ----------------------------------------------------------------------------
module tone_dial_sequencer_core
    import tds_pkg::*;
#(
    parameter int MAX_CODES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [TICK_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] code_char
    input  logic [1:0]          s_tuser,   // [1:0] opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata    // [0] drive_change, [1] tone_on,
                                           // [9:2] tone_code, [10] idle_now,
                                           // [12:11] status, [15:13] zero
);

    tds_cmd_t          cmd;
    logic              drive_change, tone_on, idle_now;
    logic [CHAR_W-1:0] tone_code;
    logic [STAT_W-1:0] status;

    tds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tds_datapath #(
        .MAX_CODES (MAX_CODES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .opcode       (s_tuser),
        .code_char    (s_tdata),
        .cmd          (cmd),
        .drive_change (drive_change),
        .tone_on      (tone_on),
        .tone_code    (tone_code),
        .idle_now     (idle_now),
        .status       (status)
    );

    assign m_tdata = {3'b000, status, idle_now, tone_code, tone_on, drive_change};

endmodule

[rtl/tds_datapath.sv]
// ----------------------------------------------------------------------------
// Tone dial sequencer datapath
// Config registers, sequencer state, code store and the result register.
// ----------------------------------------------------------------------------
module tds_datapath
    import tds_pkg::*;
#(
    parameter int MAX_CODES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [TICK_W-1:0]    cfg_wdata,
    input  logic [OP_W-1:0]      opcode,
    input  logic [CHAR_W-1:0]    code_char,
    input  tds_cmd_t             cmd,
    output logic                 drive_change,
    output logic                 tone_on,
    output logic [CHAR_W-1:0]    tone_code,
    output logic                 idle_now,
    output logic [STAT_W-1:0]    status
);

    localparam int IDX_W = $clog2(MAX_CODES);
    localparam int CNT_W = $clog2(MAX_CODES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CODES);

    logic [TICK_W-1:0]  space_reg, mark_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next, elapsed_inc;
    logic [IDX_W-1:0]   play_reg, play_next, play_inc;
    logic [CNT_W-1:0]   load_reg, load_next;
    logic [IDX_W-1:0]   len_reg, len_next;
    logic               change;
    logic [STAT_W-1:0]  stat;
    logic               mem_we;

    logic [CHAR_W-1:0]  code_mem [MAX_CODES];
    logic [CHAR_W-1:0]  rdata_reg;
    logic               change_reg;
    logic [STAT_W-1:0]  stat_reg;

    logic               drive_change_reg, tone_on_reg, idle_now_reg;
    logic [CHAR_W-1:0]  tone_code_reg;
    logic [STAT_W-1:0]  status_reg;

    // next sequencer state for the word on the input
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        play_next    = play_reg;
        load_next    = load_reg;
        len_next     = len_reg;
        change       = 1'b0;
        stat         = ST_OK;
        mem_we       = 1'b0;
        elapsed_inc  = (phase_reg != PH_IDLE && elapsed_reg != TICK_SAT) ?
                       elapsed_reg + TICK_W'(1) : elapsed_reg;
        play_inc     = play_reg + IDX_W'(1);
        case (opcode)
            OP_TICK: begin
                elapsed_next = elapsed_inc;
                case (phase_reg)
                    PH_IDLE: ;
                    PH_SPACE: begin
                        if (elapsed_inc >= space_reg) begin
                            phase_next   = PH_MARK;
                            elapsed_next = '0;
                            change       = 1'b1;
                        end
                    end
                    PH_MARK: begin
                        if (elapsed_inc >= mark_reg) begin
                            change       = 1'b1;
                            play_next    = play_inc;
                            phase_next   = (play_inc >= len_reg) ? PH_IDLE : PH_SPACE;
                            elapsed_next = '0;
                        end
                    end
                    default: begin
                        // stray phase code: drop the tone and go idle
                        change     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            OP_APPEND: begin
                if (phase_reg != PH_IDLE) begin
                    stat = ST_BUSY;
                end else if (load_reg < CNT_MAX) begin
                    mem_we    = 1'b1;
                    load_next = load_reg + CNT_W'(1);
                end
            end
            OP_START: begin
                if (phase_reg != PH_IDLE) begin
                    stat = ST_BUSY;
                end else begin
                    if (load_reg == '0 || load_reg >= CNT_MAX) begin
                        stat = ST_LEN;
                    end else begin
                        len_next     = load_reg[IDX_W-1:0];
                        play_next    = '0;
                        elapsed_next = '0;
                        phase_next   = PH_MARK;
                        change       = 1'b1;
                    end
                    load_next = '0;
                end
            end
            default: ;
        endcase
    end

    // config registers and sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_reg   <= SPACE_RST;
            mark_reg    <= MARK_RST;
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            play_reg    <= '0;
            load_reg    <= '0;
            len_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SPACE: space_reg <= cfg_wdata;
                    CFG_MARK:  mark_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.step) begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                play_reg    <= play_next;
                load_reg    <= load_next;
                len_reg     <= len_next;
            end
        end
    end

    // code store: one write port, one registered read at the next play index
    always_ff @(posedge aclk) begin
        if (cmd.step && mem_we) begin
            code_mem[load_reg[IDX_W-1:0]] <= code_char;
        end
        if (cmd.step) begin
            rdata_reg  <= code_mem[play_next];
            change_reg <= change;
            stat_reg   <= stat;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            drive_change_reg <= change_reg;
            tone_on_reg      <= (phase_reg == PH_MARK);
            tone_code_reg    <= (phase_reg == PH_MARK) ? rdata_reg : '0;
            idle_now_reg     <= (phase_reg == PH_IDLE);
            status_reg       <= stat_reg;
        end
    end

    assign drive_change = drive_change_reg;
    assign tone_on      = tone_on_reg;
    assign tone_code    = tone_code_reg;
    assign idle_now     = idle_now_reg;
    assign status       = status_reg;

endmodule

[rtl/tds_ctrl.sv]
// ----------------------------------------------------------------------------
// Tone dial sequencer controller
// Handshake state machine: accept a word, fetch the code, hold the result.
// ----------------------------------------------------------------------------
`include "tone_dial_sequencer_core_defines.svh"

module tds_ctrl
    import tds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output tds_cmd_t cmd
);

    localparam logic [1:0] S_WAIT = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == S_WAIT);
    assign m_tvalid = (state_reg == S_SEND);
    assign accept   = s_tvalid && s_tready;

    // commands to the datapath
    always_comb begin
        cmd.step  = accept;
        cmd.latch = (state_reg == S_READ);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_WAIT: if (accept) begin
                state_next = S_READ;
            end
            S_READ: state_next = S_SEND;
            S_SEND: if (m_tready) begin
                state_next = S_WAIT;
            end
            default: state_next = S_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WAIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // checks
    `TDS_ASSERT_NOW(a_one_side, aclk, aresetn, m_tvalid, !s_tready, "accept while result pending")
    `TDS_ASSERT_NEXT(a_latch_after_step, aclk, aresetn, cmd.step, cmd.latch, "result not latched")
    `TDS_ASSERT_NEXT(a_send_after_latch, aclk, aresetn, cmd.latch, m_tvalid, "result not offered")
    `TDS_ASSERT_NEXT(a_free_after_take, aclk, aresetn, m_tvalid && m_tready, s_tready, "not ready after take")

endmodule
